// ===== rtl/stbs_pkg.sv =====
// shared constants, codes and controller/datapath types for the sorted table search
package stbs_pkg;

	// default table capacity in words
	localparam int TABLE_DEPTH_DEF = 1024;

	// field widths
	localparam int WORD_W = 32;
	localparam int CMD_W  = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_CMP,
		ST_EQ,
		ST_RESP
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic clear;   // empty the table
		logic append;  // store word at the fill position
		logic load;    // latch key, open the range over the filled part
		logic probe;   // issue a table read at the middle or the single entry
		logic narrow;  // keep the upper or lower half after a probe
		logic settle;  // record equality against the single entry
		logic miss;    // record an empty range
	} ctrl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic span_zero;
		logic span_one;
	} dp_status_t;

endpackage

// ===== rtl/stbs_ram.sv =====
// generic single-clock RAM, one write port and one registered read port
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/stbs_dp.sv =====
// datapath: table memory, fill count, search range and result flag
module stbs_dp #(
	parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  stbs_pkg::ctrl_cmd_t               cmd,
	input  logic signed [stbs_pkg::WORD_W-1:0] value,
	output stbs_pkg::dp_status_t              status,
	output logic                              found
);

	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [CNT_W-1:0]           count_q;
	logic [CNT_W-1:0]           lo_q;
	logic [CNT_W-1:0]           hi_q;
	logic [CNT_W-1:0]           mid_q;
	logic [stbs_pkg::WORD_W-1:0] key_q;
	logic                       found_q;

	logic [CNT_W-1:0]           span;
	logic [CNT_W-1:0]           mid_w;
	logic                       full;
	logic                       wr_en;
	logic [ADDR_W-1:0]          rd_addr;
	logic [stbs_pkg::WORD_W-1:0] rd_data;
	logic                       key_ge;
	logic                       key_eq;

	// range arithmetic: middle is end minus half the length
	assign span    = hi_q - lo_q;
	assign mid_w   = hi_q - (span >> 1);
	assign full    = (count_q == CNT_W'(TABLE_DEPTH));
	assign wr_en   = cmd.append && !full;
	assign rd_addr = status.span_one ? lo_q[ADDR_W-1:0] : mid_w[ADDR_W-1:0];

	assign status.span_zero = (span == '0);
	assign status.span_one  = (span == CNT_W'(1));

	// signed compare of key against the word read back
	assign key_ge = $signed(key_q) >= $signed(rd_data);
	assign key_eq = (key_q == rd_data);

	// table memory
	stbs_ram #(
		.WIDTH (stbs_pkg::WORD_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (value),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// search range, key and probe position
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q  <= '0;
			hi_q  <= count_q;
			key_q <= value;
		end else if (cmd.narrow) begin
			if (key_ge) begin
				lo_q <= mid_q;
			end else begin
				hi_q <= mid_q;
			end
		end
		if (cmd.probe) begin
			mid_q <= mid_w;
		end
	end

	// result flag
	always_ff @(posedge clk) begin
		if (cmd.miss) begin
			found_q <= 1'b0;
		end else if (cmd.settle) begin
			found_q <= key_eq;
		end
	end

	assign found = found_q;

endmodule

// ===== rtl/stbs_ctrl.sv =====
// controller: command decode and search sequencing
module stbs_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [stbs_pkg::CMD_W-1:0]    command,
	input  stbs_pkg::dp_status_t          status,
	output stbs_pkg::ctrl_cmd_t           cmd,
	output logic                          busy,
	output logic                          done
);

	stbs_pkg::state_t state_q;
	stbs_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stbs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			stbs_pkg::ST_IDLE: begin
				if (start && command == stbs_pkg::CMD_QUERY) begin
					state_d = stbs_pkg::ST_STEP;
				end
			end
			stbs_pkg::ST_STEP: begin
				if (status.span_zero) begin
					state_d = stbs_pkg::ST_RESP;
				end else if (status.span_one) begin
					state_d = stbs_pkg::ST_EQ;
				end else begin
					state_d = stbs_pkg::ST_CMP;
				end
			end
			stbs_pkg::ST_CMP:  state_d = stbs_pkg::ST_STEP;
			stbs_pkg::ST_EQ:   state_d = stbs_pkg::ST_RESP;
			stbs_pkg::ST_RESP: state_d = stbs_pkg::ST_IDLE;
			default:           state_d = stbs_pkg::ST_IDLE;
		endcase
	end

	// datapath commands and handshake outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			stbs_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					case (command)
						stbs_pkg::CMD_CLEAR:  cmd.clear  = 1'b1;
						stbs_pkg::CMD_APPEND: cmd.append = 1'b1;
						stbs_pkg::CMD_QUERY:  cmd.load   = 1'b1;
						default:              cmd        = '0;
					endcase
				end
			end
			stbs_pkg::ST_STEP: begin
				if (status.span_zero) begin
					cmd.miss = 1'b1;
				end else begin
					cmd.probe = 1'b1;
				end
			end
			stbs_pkg::ST_CMP:  cmd.narrow = 1'b1;
			stbs_pkg::ST_EQ:   cmd.settle = 1'b1;
			stbs_pkg::ST_RESP: done       = 1'b1;
			default:           cmd        = '0;
		endcase
	end

endmodule

// ===== rtl/sorted_table_binary_search.sv =====
// top level: sorted table with binary search over a table memory with one write port and one registered read port
//
//   channel   ports                      handshake
//   input     command, value             beat taken when start high and busy low
//   result    found                      beat shown for one cycle with done high
//
// clear and append are taken while idle; busy stays low and the next beat may follow at once.
// a query halves the range over the n filled entries until one is left, then tests that entry;
// each halving is one read of the table memory, whose read is registered.
// arst_n clears the fill count and the controller; table contents stay undefined.
// the receiver cannot stall: the result beat is taken in the cycle done is high.
module sorted_table_binary_search #(
	parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [stbs_pkg::CMD_W-1:0]        command,
	input  logic signed [stbs_pkg::WORD_W-1:0] value,
	output logic                              done,
	output logic                              found
);

	stbs_pkg::ctrl_cmd_t  cmd;
	stbs_pkg::dp_status_t status;

	// controller
	stbs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.status  (status),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done)
	);

	// datapath
	stbs_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.value  (value),
		.status (status),
		.found  (found)
	);

endmodule
